/* hdl/spline_curve_tessellator_assert.svh */
// Assertion macros shared by the spline tessellator RTL.
// Needs a signal named clock and a signal named reset in the including scope.
`ifndef SPLINE_CURVE_TESSELLATOR_ASSERT_SVH
`define SPLINE_CURVE_TESSELLATOR_ASSERT_SVH

// Same-cycle implication.
`define SCT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sct assertion failed");

// Next-cycle implication.
`define SCT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sct assertion failed");

`endif

/* hdl/sct_pkg.sv */
// Types and constants for the spline curve tessellator.
// No dependencies; used by every module of the block but the queue.
package sct_pkg;

   typedef struct packed {
      logic               start_path;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
   } req_type;

   typedef struct packed {
      logic signed [31:0] qx;
      logic signed [31:0] qy;
      logic signed [31:0] qz;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] p1;
      logic signed [31:0] p2;
      logic signed [32:0] d0;   // p2 - p0
      logic signed [32:0] d1;   // p3 - p1
   } axis_type;

   typedef struct packed {
      logic [5:0]          n;
      logic [16:0]         q0;  // floor(65536 / n)
      logic [5:0]          r0;  // 65536 mod n
      axis_type [2:0]      axes;
   } job_type;

   localparam logic [5:0]  SEG_RESET = 6'd8;
   localparam logic [16:0] T_ONE     = 17'h10000;

   function automatic logic [16:0] recip(input logic [5:0] n);
      logic [16:0] q;
      case (n)
         6'd1: q = 17'd65536;   6'd2: q = 17'd32768;   6'd3: q = 17'd21845;
         6'd4: q = 17'd16384;   6'd5: q = 17'd13107;   6'd6: q = 17'd10922;
         6'd7: q = 17'd9362;    6'd8: q = 17'd8192;    6'd9: q = 17'd7281;
         6'd10: q = 17'd6553;   6'd11: q = 17'd5957;   6'd12: q = 17'd5461;
         6'd13: q = 17'd5041;   6'd14: q = 17'd4681;   6'd15: q = 17'd4369;
         6'd16: q = 17'd4096;   6'd17: q = 17'd3855;   6'd18: q = 17'd3640;
         6'd19: q = 17'd3449;   6'd20: q = 17'd3276;   6'd21: q = 17'd3120;
         6'd22: q = 17'd2978;   6'd23: q = 17'd2849;   6'd24: q = 17'd2730;
         6'd25: q = 17'd2621;   6'd26: q = 17'd2520;   6'd27: q = 17'd2427;
         6'd28: q = 17'd2340;   6'd29: q = 17'd2259;   6'd30: q = 17'd2184;
         6'd31: q = 17'd2114;   6'd32: q = 17'd2048;   6'd33: q = 17'd1985;
         6'd34: q = 17'd1927;   6'd35: q = 17'd1872;   6'd36: q = 17'd1820;
         6'd37: q = 17'd1771;   6'd38: q = 17'd1724;   6'd39: q = 17'd1680;
         6'd40: q = 17'd1638;   6'd41: q = 17'd1598;   6'd42: q = 17'd1560;
         6'd43: q = 17'd1524;   6'd44: q = 17'd1489;   6'd45: q = 17'd1456;
         6'd46: q = 17'd1424;   6'd47: q = 17'd1394;   6'd48: q = 17'd1365;
         6'd49: q = 17'd1337;   6'd50: q = 17'd1310;   6'd51: q = 17'd1285;
         6'd52: q = 17'd1260;   6'd53: q = 17'd1236;   6'd54: q = 17'd1213;
         6'd55: q = 17'd1191;   6'd56: q = 17'd1170;   6'd57: q = 17'd1149;
         6'd58: q = 17'd1129;   6'd59: q = 17'd1110;   6'd60: q = 17'd1092;
         6'd61: q = 17'd1074;   6'd62: q = 17'd1057;   6'd63: q = 17'd1040;
         default: q = 17'd65536;
      endcase
      return q;
   endfunction

endpackage

/* hdl/sct_front.sv */
// Front end: takes control points, keeps the three-point window and
// builds span jobs. Depends on sct_pkg.
module sct_front #(
   parameter int MAX_SEGMENTS = 63
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sct_pkg::req_type req_data,
   input  logic [5:0]       seg_cfg,
   input  logic             job_full,
   output logic             job_push,
   output sct_pkg::job_type job_data
);

   localparam logic [5:0] MAX_N = 6'(MAX_SEGMENTS);

   logic signed [31:0] win_ff [3][3];
   logic signed [31:0] win_in [3][3];
   logic [1:0]         held_ff, held_in;
   logic               accept;
   logic signed [31:0] pnew [3];
   logic [5:0]         n_eff;
   logic [22:0]        qn;
   logic [22:0]        rem_w;

   assign req_ready = !job_full;
   assign accept    = req_valid && req_ready;
   assign pnew[0]   = req_data.px;
   assign pnew[1]   = req_data.py;
   assign pnew[2]   = req_data.pz;

   always_comb begin
      if (seg_cfg == 6'd0) begin
         n_eff = 6'd1;
      end else if (seg_cfg > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = seg_cfg;
      end
   end

   assign qn    = 23'(sct_pkg::recip(n_eff)) * 23'(n_eff);
   assign rem_w = 23'(sct_pkg::T_ONE) - qn;

   always_comb begin
      job_data.n  = n_eff;
      job_data.q0 = sct_pkg::recip(n_eff);
      job_data.r0 = rem_w[5:0];
      for (int a = 0; a < 3; a++) begin
         job_data.axes[a].p1 = win_ff[1][a];
         job_data.axes[a].p2 = win_ff[2][a];
         job_data.axes[a].d0 = 33'(win_ff[2][a]) - 33'(win_ff[0][a]);
         job_data.axes[a].d1 = 33'(pnew[a]) - 33'(win_ff[1][a]);
      end
   end

   assign job_push = accept && !req_data.start_path && (held_ff == 2'd3);

   always_comb begin
      win_in  = win_ff;
      held_in = held_ff;
      if (accept) begin
         for (int a = 0; a < 3; a++) begin
            // a new path drops the held points before this one goes in
            win_in[0][a] = req_data.start_path ? 32'sd0 : win_ff[1][a];
            win_in[1][a] = req_data.start_path ? 32'sd0 : win_ff[2][a];
            win_in[2][a] = pnew[a];
         end
         if (req_data.start_path) begin
            held_in = 2'd1;
         end else if (held_ff != 2'd3) begin
            held_in = held_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
         for (int p = 0; p < 3; p++) begin
            for (int a = 0; a < 3; a++) begin
               win_ff[p][a] <= 32'sd0;
            end
         end
      end else begin
         held_ff <= held_in;
         win_ff  <= win_in;
      end
   end

endmodule

/* hdl/sct_queue.sv */
// Two-entry job queue between the front end and the evaluator.
// Depends on nothing but its width parameter.
module sct_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] head
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* hdl/sct_back.sv */
// Back end: steps t over a span and evaluates the Hermite blend in a
// stalling pipeline with a registered result. Depends on sct_pkg.
`include "spline_curve_tessellator_assert.svh"
module sct_back #(
   parameter int COORD_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  sct_pkg::job_type job_head,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sct_pkg::rsp_type rsp_data
);

   localparam int SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam logic signed [55:0] SAT_HI = (56'sd1 <<< (SAT_W - 1)) - 56'sd1;
   localparam logic signed [55:0] SAT_LO = -SAT_HI - 56'sd1;

   logic en;

   // issuer
   logic             active_ff;
   sct_pkg::job_type job_ff;
   logic [5:0]       j_ff;
   logic [16:0]      t_ff;
   logic [5:0]       rem_ff;
   logic [6:0]       rem_sum;
   logic             issue_last;

   // pipeline stages
   logic                    a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff;
   logic                    a_last_ff, b_last_ff, c_last_ff, d_last_ff, e_last_ff;
   sct_pkg::axis_type [2:0] a_ax_ff, b_ax_ff, c_ax_ff, d_ax_ff;
   logic [16:0]             a_t_ff, b_t_ff, c_t_ff;
   logic [16:0]             b_t2_ff, c_t2_ff;
   logic [16:0]             c_t3_ff;
   logic [33:0]             sq, cu;
   logic signed [19:0]      h00, h01, h10, h11, st, st2, st3;
   logic signed [19:0]      d_h_ff [4];
   logic signed [55:0]      e_m_ff [3][4];
   logic signed [55:0]      sum [3];
   logic signed [55:0]      shr [3];
   logic signed [31:0]      sat [3];

   logic             rsp_valid_ff;
   sct_pkg::rsp_type rsp_data_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign job_pop   = en && !active_ff && job_valid;
   assign issue_last = (j_ff == job_ff.n);
   assign rem_sum   = 7'(rem_ff) + 7'(job_ff.r0);

   assign sq  = 34'(a_t_ff) * 34'(a_t_ff);
   assign cu  = 34'(b_t2_ff) * 34'(b_t_ff);
   assign st  = 20'(c_t_ff);
   assign st2 = 20'(c_t2_ff);
   assign st3 = 20'(c_t3_ff);

   always_comb begin
      h00 = 20'sd2 * st3 - 20'sd3 * st2 + 20'sd65536;
      h01 = 20'sd3 * st2 - 20'sd2 * st3;
      h10 = st3 - 20'sd2 * st2 + st;
      h11 = st3 - st2;
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sum[a] = e_m_ff[a][0] + e_m_ff[a][1] + e_m_ff[a][2] + e_m_ff[a][3];
         shr[a] = sum[a] >>> 16;
         if (shr[a] > SAT_HI) begin
            sat[a] = SAT_HI[31:0];
         end else if (shr[a] < SAT_LO) begin
            sat[a] = SAT_LO[31:0];
         end else begin
            sat[a] = shr[a][31:0];
         end
      end
   end

   // payload stages, no reset
   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job_head;
      end
      if (en) begin
         a_t_ff    <= t_ff;
         a_last_ff <= issue_last;
         a_ax_ff   <= job_ff.axes;
         b_t_ff    <= a_t_ff;
         b_t2_ff   <= sq[32:16];
         b_last_ff <= a_last_ff;
         b_ax_ff   <= a_ax_ff;
         c_t_ff    <= b_t_ff;
         c_t2_ff   <= b_t2_ff;
         c_t3_ff   <= cu[32:16];
         c_last_ff <= b_last_ff;
         c_ax_ff   <= b_ax_ff;
         d_h_ff[0] <= h00;
         d_h_ff[1] <= h01;
         d_h_ff[2] <= h10;
         d_h_ff[3] <= h11;
         d_last_ff <= c_last_ff;
         d_ax_ff   <= c_ax_ff;
         for (int a = 0; a < 3; a++) begin
            e_m_ff[a][0] <= d_ax_ff[a].p1 * d_h_ff[0];
            e_m_ff[a][1] <= d_ax_ff[a].p2 * d_h_ff[1];
            e_m_ff[a][2] <= d_ax_ff[a].d0 * d_h_ff[2];
            e_m_ff[a][3] <= d_ax_ff[a].d1 * d_h_ff[3];
         end
         e_last_ff <= d_last_ff;
         rsp_data_ff.qx          <= sat[0];
         rsp_data_ff.qy          <= sat[1];
         rsp_data_ff.qz          <= sat[2];
         rsp_data_ff.last_of_run <= e_last_ff;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         j_ff         <= 6'd0;
         t_ff         <= 17'd0;
         rem_ff       <= 6'd0;
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         d_vld_ff     <= 1'b0;
         e_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff     <= active_ff;
         b_vld_ff     <= a_vld_ff;
         c_vld_ff     <= b_vld_ff;
         d_vld_ff     <= c_vld_ff;
         e_vld_ff     <= d_vld_ff;
         rsp_valid_ff <= e_vld_ff;
         if (active_ff) begin
            if (issue_last) begin
               active_ff <= 1'b0;
            end
            j_ff <= j_ff + 6'd1;
            // advance t by q0, carry the remainder of 65536/n
            if (rem_sum >= 7'(job_ff.n)) begin
               rem_ff <= 6'(rem_sum - 7'(job_ff.n));
               t_ff   <= t_ff + job_ff.q0 + 17'd1;
            end else begin
               rem_ff <= rem_sum[5:0];
               t_ff   <= t_ff + job_ff.q0;
            end
         end else if (job_valid) begin
            active_ff <= 1'b1;
            j_ff      <= 6'd0;
            t_ff      <= 17'd0;
            rem_ff    <= 6'd0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SCT_ASSERT_NOW(pop_when_idle, job_pop, !active_ff)
   `SCT_ASSERT_NOW(t_ends_at_one, a_vld_ff && a_last_ff, a_t_ff == sct_pkg::T_ONE)
   `SCT_ASSERT_NOW(rem_below_n, active_ff, rem_ff < job_ff.n)

endmodule

/* hdl/spline_curve_tessellator.sv */
// Spline tessellator: one request in, segments+1 curve points out per span.
// A span-closing job passes the queue, the t stepper, stages a to e and the result register.
// One curve point per cycle while rsp_ready allows; the t stepper takes one span at a time.
// Requests that close no span push no job but still wait while the queue is full; up to two spans wait in the queue.
// Synchronous active-high reset clears the window, queue, pipeline and sets segments to 8.
module spline_curve_tessellator #(
   parameter int MAX_SEGMENTS = 63,
   parameter int COORD_WIDTH  = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sct_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sct_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [5:0]       csr_wdata
);

   localparam int JOB_W = $bits(sct_pkg::job_type);

   logic [5:0]       seg_ff;
   logic             job_push, job_pop, job_full, job_valid;
   sct_pkg::job_type job_in, job_head;
   logic [JOB_W-1:0] head_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= sct_pkg::SEG_RESET;
      end else if (csr_we) begin
         seg_ff <= csr_wdata;
      end
   end

   sct_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .seg_cfg   (seg_ff),
      .job_full  (job_full),
      .job_push  (job_push),
      .job_data  (job_in)
   );

   sct_queue #(.WIDTH(JOB_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .full      (job_full),
      .not_empty (job_valid),
      .head      (head_bits)
   );

   assign job_head = sct_pkg::job_type'(head_bits);

   sct_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_head  (job_head),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* bench/spline_curve_tessellator_checker.sv */
// Checker for the spline curve tessellator: watches request and response channels,
// predicts curve points from the control-point window and compares them field by field.
// Depends on sct_pkg.
module spline_curve_tessellator_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  sct_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  sct_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [5:0]       csr_wdata,
   output int               fail_count,
   output int               pending_points,
   output int               points_seen
);

   sct_pkg::rsp_type curve_q[$];
   logic [5:0]       seg_reg;
   logic [31:0]      win_x[3], win_y[3], win_z[3];
   int               held;

   task automatic report_mismatch(input string what, input sct_pkg::rsp_type got,
         input sct_pkg::rsp_type want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   function automatic logic [31:0] blend_axis(input logic [31:0] a0, input logic [31:0] a1,
         input logic [31:0] a2, input logic [31:0] a3, input longint h00,
         input longint h01, input longint h10, input longint h11);
      longint p0, p1, p2, p3, acc;
      p0 = longint'($signed(a0));
      p1 = longint'($signed(a1));
      p2 = longint'($signed(a2));
      p3 = longint'($signed(a3));
      acc = p1 * h00 + p2 * h01 + (p2 - p0) * h10 + (p3 - p1) * h11;
      acc = acc >>> 16;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      return acc[31:0];
   endfunction

   task automatic predict_span(input sct_pkg::req_type r);
      longint n, t, t2, t3, h00, h01, h10, h11;
      sct_pkg::rsp_type e;
      if (r.start_path) held = 0;
      if (held >= 3) begin
         n = seg_reg;
         if (n < 1) n = 1;
         if (n > 63) n = 63;
         for (longint j = 0; j <= n; j++) begin
            t = (j * 65536) / n;
            t2 = (t * t) >>> 16;
            t3 = (t2 * t) >>> 16;
            h00 = 2 * t3 - 3 * t2 + 65536;
            h01 = 3 * t2 - 2 * t3;
            h10 = t3 - 2 * t2 + t;
            h11 = t3 - t2;
            e.qx = blend_axis(win_x[0], win_x[1], win_x[2], r.px, h00, h01, h10, h11);
            e.qy = blend_axis(win_y[0], win_y[1], win_y[2], r.py, h00, h01, h10, h11);
            e.qz = blend_axis(win_z[0], win_z[1], win_z[2], r.pz, h00, h01, h10, h11);
            e.last_of_run = (j == n);
            curve_q = {curve_q, e};
         end
      end
      win_x[0] = win_x[1]; win_x[1] = win_x[2]; win_x[2] = r.px;
      win_y[0] = win_y[1]; win_y[1] = win_y[2]; win_y[2] = r.py;
      win_z[0] = win_z[1]; win_z[1] = win_z[2]; win_z[2] = r.pz;
      if (held < 3) held++;
   endtask

   always @(posedge clock) begin
      sct_pkg::rsp_type want;
      if (reset) begin
         seg_reg = sct_pkg::SEG_RESET;
         held = 0;
         curve_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            points_seen++;
            if (curve_q.size() == 0) begin
               report_mismatch("unexpected point", rsp_data, '0);
            end else begin
               want = curve_q.pop_front();
               if (rsp_data.qx !== want.qx) report_mismatch("qx", rsp_data, want);
               if (rsp_data.qy !== want.qy) report_mismatch("qy", rsp_data, want);
               if (rsp_data.qz !== want.qz) report_mismatch("qz", rsp_data, want);
               if (rsp_data.last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", rsp_data, want);
            end
         end
         if (req_valid && req_ready) predict_span(req_data);
         if (csr_we) seg_reg = csr_wdata;
      end
      pending_points = curve_q.size();
   end

   initial begin
      fail_count = 0;
      pending_points = 0;
      points_seen = 0;
   end
endmodule

/* bench/tb.sv */
// Testbench top for spline_curve_tessellator: drives control points, segment counts
// and response stalls; the checker module predicts and compares. Depends on sct_pkg.
module tb;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   sct_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   sct_pkg::rsp_type rsp_data;
   logic             csr_we = 0;
   logic [5:0]       csr_wdata = '0;
   int               fail_count, pending_points, points_seen;
   int               sent = 0;
   bit               calm = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   spline_curve_tessellator u_top (.*);

   spline_curve_tessellator_checker u_chk (.*);

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= calm || ($urandom_range(99) >= 13);
   end

   function automatic logic [31:0] rand_coord(input int kind);
      case (kind)
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(2047) - 1024;
         3: return $urandom_range(65535) - 32768;
         default: return $urandom();
      endcase
   endfunction

   // valid stays up after acceptance; the next call replaces the payload or drops valid
   task automatic send_point(input logic sp, input logic [31:0] x, input logic [31:0] y,
         input logic [31:0] z);
      if (!calm && $urandom_range(99) < 13) begin
         req_valid <= 0;
         @(posedge clock);
         while (!calm && $urandom_range(99) < 13) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{start_path: sp, px: x, py: y, pz: z};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain_wait();
      req_valid <= 0;
      @(posedge clock);
      while (pending_points != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_segments(input logic [5:0] v);
      drain_wait();
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic random_path(input int len);
      int k;
      k = $urandom_range(4);
      for (int i = 0; i < len; i++)
         send_point(i == 0 ? 1'b1 : ($urandom_range(19) == 0), rand_coord(k),
            rand_coord(k), rand_coord(k));
   endtask

   initial begin
      logic [5:0] segs[$] = '{6'd0, 6'd1, 6'd63, 6'd2, 6'd5};
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: reset count 8, extremes, short path, start mid-span
      send_point(1, 32'h7fffffff, 32'h80000000, 32'h0);
      send_point(0, 32'h80000000, 32'h7fffffff, 32'hffffffff);
      send_point(0, 32'h7fffffff, 32'h80000000, 32'h1);
      send_point(0, 32'h80000000, 32'h7fffffff, 32'h100);
      send_point(0, 32'h00000100, 32'hffffff00, 32'h7fffffff);
      send_point(1, 32'h10, 32'h20, 32'h30);
      send_point(0, 32'h40, 32'h50, 32'h60);
      send_point(1, 32'h1, 32'h2, 32'h3);
      send_point(0, 32'h1000, 32'h2000, 32'h3000);
      send_point(0, 32'h5555aaaa, 32'haaaa5555, 32'hffffffff);
      send_point(0, 32'h0, 32'h0, 32'h0);
      send_point(0, 32'hdeadbeef, 32'h12345678, 32'h80000001);
      foreach (segs[i]) begin
         write_segments(segs[i]);
         random_path(6);
      end
      write_segments(6'd8);
      while (sent < 350) begin
         if ($urandom_range(9) == 0) write_segments($urandom_range(63));
         if ($urandom_range(7) == 0) drain_wait();
         calm = (sent > 150 && sent < 200);
         random_path($urandom_range(8, 2));
      end
      calm = 0;
      drain_wait();
      $display("sent %0d control points, checked %0d curve points over several segment counts",
         sent, points_seen);
      if (fail_count == 0) $display("** spline_curve_tessellator: PASSED **");
      else $display("** spline_curve_tessellator: FAILED **");
      $finish;
   end

   initial begin
      #20000000;
      $display("** spline_curve_tessellator: FAILED **");
      $finish;
   end
endmodule
